// ===== hdl/cavb_pkg.sv =====
package cavb_pkg;

    localparam int NUM_COMBS = 8;
    localparam int NUM_AP    = 4;
    localparam int AP_DEPTH  = 2048;
    localparam int AP_AW     = 11;
    localparam int AP_IW     = 10;
    localparam int CFG_IW    = 3;
    localparam int COEF_W    = 16;
    localparam int PDLY_W    = 12;

    typedef enum logic [CFG_IW-1:0] {
        REG_FEEDBACK,
        REG_DAMPING,
        REG_WET_GAIN,
        REG_DRY_GAIN,
        REG_HP_POLE,
        REG_LP_POLE,
        REG_ROOM_SCALE,
        REG_PRE_DELAY
    } t_reg_idx;

    localparam logic [COEF_W-1:0] RST_FEEDBACK   = 16'd60986;
    localparam logic [COEF_W-1:0] RST_DAMPING    = 16'd32768;
    localparam logic [COEF_W-1:0] RST_WET_GAIN   = 16'd876;
    localparam logic [COEF_W-1:0] RST_DRY_GAIN   = 16'd16384;
    localparam logic [COEF_W-1:0] RST_HP_POLE    = 16'd62220;
    localparam logic [COEF_W-1:0] RST_LP_POLE    = 16'd34923;
    localparam logic [COEF_W-1:0] RST_ROOM_SCALE = 16'd19615;
    localparam logic [PDLY_W-1:0] RST_PRE_DELAY  = 12'd0;

    localparam logic [10:0] COMB_BASE [NUM_COMBS] = '{
        11'd1116, 11'd1188, 11'd1277, 11'd1356, 11'd1422, 11'd1491, 11'd1557, 11'd1617
    };

    localparam logic [AP_IW-1:0] AP_LEN [NUM_AP] = '{10'd605, 10'd480, 10'd371, 10'd245};
    localparam logic [AP_AW-1:0] AP_OFF [NUM_AP] = '{11'd0, 11'd605, 11'd1085, 11'd1456};

endpackage

// ===== hdl/comb_allpass_reverb_top.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_stall         i_sample
// output    out        o_valid / i_stall         o_out_sample
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each item runs through these steps, acceptance to next acceptance: the idle step that accepts it,
// pre-delay read and fetch, per comb length multiply, index, read, damping multiply,
// store update, feedback multiply and write, per allpass read and write, and multiply,
// multiply and sum each for highpass, lowpass and output mix, all through one shared multiplier
// and one read and one write port per delay memory. A new sample is taken only in the idle step.
// After reset a clearing pass zeroes all delay memories, one entry per cycle, over
// max(PREDELAY_DEPTH, 8*COMB_LINE_DEPTH, 2048) addresses (16384 by default).
// The last step holds while the output register is full and stalled.
module comb_allpass_reverb_top #(
    parameter int COMB_LINE_DEPTH = 2048,
    parameter int PREDELAY_DEPTH  = 4096,
    parameter int SAMPLE_BITS     = 16,
    parameter int INTERNAL_BITS   = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [SAMPLE_BITS-1:0]        o_out_sample,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [cavb_pkg::CFG_IW-1:0]          i_cfg_index,
    input  logic [cavb_pkg::COEF_W-1:0]          i_cfg_data
);

    localparam int SB   = SAMPLE_BITS;
    localparam int IB   = INTERNAL_BITS;
    localparam int AW   = ((IB > SB) ? IB : SB) + 2;
    localparam int PW   = AW + 19;
    localparam int EW   = PW + 2;
    localparam int CIW  = $clog2(COMB_LINE_DEPTH);
    localparam int LW   = $clog2(COMB_LINE_DEPTH + 1);
    localparam int CMD  = cavb_pkg::NUM_COMBS * COMB_LINE_DEPTH;
    localparam int CAW  = $clog2(CMD);
    localparam int PAW  = $clog2(PREDELAY_DEPTH);
    localparam int DW   = (PAW > cavb_pkg::PDLY_W) ? PAW : cavb_pkg::PDLY_W;
    localparam int CLR_A = (PREDELAY_DEPTH > CMD) ? PREDELAY_DEPTH : CMD;
    localparam int CLR_N = (CLR_A > cavb_pkg::AP_DEPTH) ? CLR_A : cavb_pkg::AP_DEPTH;
    localparam int CLW  = $clog2(CLR_N + 1);
    localparam int KW   = $clog2(cavb_pkg::NUM_COMBS);

    localparam logic signed [EW-1:0] E_ONE = 1;
    localparam logic signed [EW-1:0] IMAX = {{(EW-IB+1){1'b0}}, {(IB-1){1'b1}}};
    localparam logic signed [EW-1:0] IMIN = {{(EW-IB+1){1'b1}}, {(IB-1){1'b0}}};
    localparam logic signed [EW-1:0] SMAX = {{(EW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [EW-1:0] SMIN = {{(EW-SB+1){1'b1}}, {(SB-1){1'b0}}};
    localparam logic [DW-1:0] PD_LIM = DW'(PREDELAY_DEPTH - 1);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_PD_RD, S_PD_GET,
        S_C_LEN, S_C_IDX, S_C_RD, S_C_MUL1, S_C_ST, S_C_MUL2, S_C_WR,
        S_A_RD, S_A_WR,
        S_H_M1, S_H_M2, S_H_SUM,
        S_L_M1, S_L_M2, S_L_SUM,
        S_O_M1, S_O_M2, S_O_SUM
    } t_state;

    function automatic logic signed [EW-1:0] rnd_fn(input logic signed [EW-1:0] v, input int s);
        logic signed [EW-1:0] h;
        begin
            h = E_ONE <<< (s - 1);
            rnd_fn = (v + h) >>> s;
        end
    endfunction

    function automatic logic signed [IB-1:0] sat_fn(input logic signed [EW-1:0] v);
        begin
            if (v > IMAX) begin
                sat_fn = IMAX[IB-1:0];
            end else if (v < IMIN) begin
                sat_fn = IMIN[IB-1:0];
            end else begin
                sat_fn = v[IB-1:0];
            end
        end
    endfunction

    function automatic logic signed [SB-1:0] sats_fn(input logic signed [EW-1:0] v);
        begin
            if (v > SMAX) begin
                sats_fn = SMAX[SB-1:0];
            end else if (v < SMIN) begin
                sats_fn = SMIN[SB-1:0];
            end else begin
                sats_fn = v[SB-1:0];
            end
        end
    endfunction

    // control and configuration
    t_state                        r_state;
    logic [CLW-1:0]                r_clr;
    logic [KW-1:0]                 r_k;
    logic [cavb_pkg::COEF_W-1:0]   r_feedback, r_damping, r_wet, r_dry;
    logic [cavb_pkg::COEF_W-1:0]   r_hp_pole, r_lp_pole, r_room;
    logic [cavb_pkg::PDLY_W-1:0]   r_pre_delay;
    logic [PAW-1:0]                r_pidx;
    logic [CIW-1:0]                r_cidx [cavb_pkg::NUM_COMBS];
    logic signed [IB-1:0]          r_store [cavb_pkg::NUM_COMBS];
    logic [cavb_pkg::AP_IW-1:0]    r_aidx [cavb_pkg::NUM_AP];
    logic signed [IB-1:0]          r_x1, r_y1, r_lp;
    logic                          r_ovalid;

    // datapath
    logic signed [SB-1:0]          r_x, r_out;
    logic                          r_d0;
    logic signed [AW-1:0]          r_wx;
    logic signed [PW-1:0]          r_prod, r_acc;
    logic [LW-1:0]                 r_len;
    logic [CIW-1:0]                r_ci;
    logic [CAW-1:0]                r_caddr;
    logic signed [IB+2:0]          r_sum;
    logic signed [IB-1:0]          r_a;
    logic [cavb_pkg::AP_IW-1:0]    r_ai;

    // memories
    logic signed [SB-1:0]          r_pd_mem [PREDELAY_DEPTH];
    logic signed [IB-1:0]          r_cm_mem [CMD];
    logic signed [IB-1:0]          r_ap_mem [cavb_pkg::AP_DEPTH];
    logic signed [SB-1:0]          r_prd;
    logic signed [IB-1:0]          r_crd, r_ard;

    logic                          pd_we, cm_we, ap_we, pd_re, cm_re, ap_re;
    logic [PAW-1:0]                pd_waddr, pd_raddr;
    logic signed [SB-1:0]          pd_wdata;
    logic [CAW-1:0]                cm_waddr, cm_raddr;
    logic signed [IB-1:0]          cm_wdata;
    logic [cavb_pkg::AP_AW-1:0]    ap_waddr, ap_raddr;
    logic signed [IB-1:0]          ap_wdata;

    logic signed [AW-1:0]          mul_a;
    logic [17:0]                   mul_b;
    logic signed [PW-1:0]          prod_c;

    logic [DW-1:0]                 pd_dw;
    logic [PAW-1:0]                pd_d;
    logic signed [EW-1:0]          len_e;
    logic [LW-1:0]                 len_c;
    logic [CIW-1:0]                c_cur, c_idx, c_nxt;
    logic [cavb_pkg::AP_IW-1:0]    a_cur, a_idx, a_nxt;
    logic signed [EW-1:0]          e_o, e_prod, e_acc, e_store, e_wx, e_a, e_ard, e_x1;
    logic signed [EW-1:0]          e_y1, e_lp, e_x, e_pd, e_wxs, e_sum, e_diff1, e_diff2;
    logic signed [AW-1:0]          wx_c;
    logic signed [IB+2:0]          sum_n;
    logic signed [IB-1:0]          st_new, cw_new, ap_w, ap_a, hp_y, lp_y, a_sum;
    logic signed [SB-1:0]          out_s;

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_out_sample = r_out;
    assign o_cfg_ready  = 1'b1;
    assign prod_c       = PW'(mul_a) * PW'($signed({1'b0, mul_b}));

    always_comb begin
        // pre-delay read position
        pd_dw    = (DW'(r_pre_delay) > PD_LIM) ? PD_LIM : DW'(r_pre_delay);
        pd_d     = pd_dw[PAW-1:0];
        pd_raddr = (r_pidx >= pd_d) ? (r_pidx - pd_d) : (r_pidx + PAW'(PREDELAY_DEPTH) - pd_d);

        // comb length, clamped to the line
        len_e = (EW'(r_prod) + EW'(16384)) >>> 15;
        if (len_e == '0) begin
            len_c = LW'(1);
        end else if (len_e > EW'(COMB_LINE_DEPTH)) begin
            len_c = LW'(COMB_LINE_DEPTH);
        end else begin
            len_c = len_e[LW-1:0];
        end
        c_cur    = r_cidx[r_k];
        c_idx    = (LW'(c_cur) >= r_len) ? '0 : c_cur;
        c_nxt    = ((LW'(r_ci) + LW'(1)) >= r_len) ? '0 : (r_ci + CIW'(1));
        cm_raddr = CAW'(r_k) * CAW'(COMB_LINE_DEPTH) + CAW'(c_idx);

        a_cur    = r_aidx[r_k[1:0]];
        a_idx    = (a_cur >= cavb_pkg::AP_LEN[r_k[1:0]]) ? '0 : a_cur;
        a_nxt    = ((r_ai + 10'd1) >= cavb_pkg::AP_LEN[r_k[1:0]]) ? '0 : (r_ai + 10'd1);
        ap_raddr = cavb_pkg::AP_OFF[r_k[1:0]] + cavb_pkg::AP_AW'(a_idx);

        // sign-extended views
        e_o     = EW'(r_crd);
        e_prod  = EW'(r_prod);
        e_acc   = EW'(r_acc);
        e_store = EW'(r_store[r_k]);
        e_wx    = EW'(r_wx);
        e_a     = EW'(r_a);
        e_ard   = EW'(r_ard);
        e_x1    = EW'(r_x1);
        e_y1    = EW'(r_y1);
        e_lp    = EW'(r_lp);
        e_x     = EW'(r_x);
        e_pd    = EW'(r_prd);
        e_sum   = EW'(r_sum);
        e_wxs   = r_d0 ? e_x : e_pd;
        wx_c    = e_wxs[AW-1:0];
        e_diff1 = e_store - e_o;
        e_diff2 = e_a - e_x1;
        sum_n   = r_sum + (IB+3)'(r_crd);

        st_new = sat_fn(e_o + rnd_fn(e_prod, 16));
        cw_new = sat_fn(e_wx + rnd_fn(e_prod, 16));
        a_sum  = sat_fn(e_sum);
        ap_w   = sat_fn(e_a + ((e_ard + E_ONE) >>> 1));
        ap_a   = sat_fn(e_ard - e_a);
        hp_y   = sat_fn(rnd_fn(e_acc + e_prod, 17));
        lp_y   = sat_fn(rnd_fn(e_acc + e_prod, 16));
        out_s  = sats_fn(rnd_fn(e_acc + e_prod, 16));

        // shared multiplier operands
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_C_LEN: begin
                mul_a = $signed(AW'(r_room));
                mul_b = 18'(cavb_pkg::COMB_BASE[r_k]);
            end
            S_C_MUL1: begin
                mul_a = e_diff1[AW-1:0];
                mul_b = 18'(r_damping);
            end
            S_C_MUL2: begin
                mul_a = e_store[AW-1:0];
                mul_b = 18'(r_feedback);
            end
            S_H_M1: begin
                mul_a = e_diff2[AW-1:0];
                mul_b = 18'd65536 + 18'(r_hp_pole);
            end
            S_H_M2: begin
                mul_a = e_y1[AW-1:0];
                mul_b = {1'b0, r_hp_pole, 1'b0};
            end
            S_L_M1: begin
                mul_a = e_a[AW-1:0];
                mul_b = 18'd65536 - 18'(r_lp_pole);
            end
            S_L_M2: begin
                mul_a = e_lp[AW-1:0];
                mul_b = 18'(r_lp_pole);
            end
            S_O_M1: begin
                mul_a = e_x[AW-1:0];
                mul_b = {r_dry, 2'b00};
            end
            S_O_M2: begin
                mul_a = e_lp[AW-1:0];
                mul_b = 18'(r_wet);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        // memory ports
        pd_we    = 1'b0;
        pd_waddr = r_pidx;
        pd_wdata = r_x;
        cm_we    = 1'b0;
        cm_waddr = r_caddr;
        cm_wdata = cw_new;
        ap_we    = 1'b0;
        ap_waddr = cavb_pkg::AP_OFF[r_k[1:0]] + cavb_pkg::AP_AW'(r_ai);
        ap_wdata = ap_w;
        pd_re    = (r_state == S_PD_RD);
        cm_re    = (r_state == S_C_RD);
        ap_re    = (r_state == S_A_RD);
        case (r_state)
            S_CLEAR: begin
                pd_we    = (r_clr < CLW'(PREDELAY_DEPTH));
                pd_waddr = r_clr[PAW-1:0];
                pd_wdata = '0;
                cm_we    = (r_clr < CLW'(CMD));
                cm_waddr = r_clr[CAW-1:0];
                cm_wdata = '0;
                ap_we    = (r_clr < CLW'(cavb_pkg::AP_DEPTH));
                ap_waddr = r_clr[cavb_pkg::AP_AW-1:0];
                ap_wdata = '0;
            end
            S_PD_RD: pd_we = 1'b1;
            S_C_WR:  cm_we = 1'b1;
            S_A_WR:  ap_we = 1'b1;
            default: begin
                pd_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pd_we) begin
            r_pd_mem[pd_waddr] <= pd_wdata;
        end
        if (pd_re) begin
            r_prd <= r_pd_mem[pd_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cm_we) begin
            r_cm_mem[cm_waddr] <= cm_wdata;
        end
        if (cm_re) begin
            r_crd <= r_cm_mem[cm_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ap_we) begin
            r_ap_mem[ap_waddr] <= ap_wdata;
        end
        if (ap_re) begin
            r_ard <= r_ap_mem[ap_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        // hold the last products while the result waits
        if (r_state != S_O_SUM || !r_ovalid || !i_stall) begin
            r_prod <= prod_c;
        end
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_k         <= '0;
            r_feedback  <= cavb_pkg::RST_FEEDBACK;
            r_damping   <= cavb_pkg::RST_DAMPING;
            r_wet       <= cavb_pkg::RST_WET_GAIN;
            r_dry       <= cavb_pkg::RST_DRY_GAIN;
            r_hp_pole   <= cavb_pkg::RST_HP_POLE;
            r_lp_pole   <= cavb_pkg::RST_LP_POLE;
            r_room      <= cavb_pkg::RST_ROOM_SCALE;
            r_pre_delay <= cavb_pkg::RST_PRE_DELAY;
            r_pidx      <= '0;
            r_cidx      <= '{default: '0};
            r_store     <= '{default: '0};
            r_aidx      <= '{default: '0};
            r_x1        <= '0;
            r_y1        <= '0;
            r_lp        <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (cavb_pkg::t_reg_idx'(i_cfg_index))
                    cavb_pkg::REG_FEEDBACK:   r_feedback  <= i_cfg_data;
                    cavb_pkg::REG_DAMPING:    r_damping   <= i_cfg_data;
                    cavb_pkg::REG_WET_GAIN:   r_wet       <= i_cfg_data;
                    cavb_pkg::REG_DRY_GAIN:   r_dry       <= i_cfg_data;
                    cavb_pkg::REG_HP_POLE:    r_hp_pole   <= i_cfg_data;
                    cavb_pkg::REG_LP_POLE:    r_lp_pole   <= i_cfg_data;
                    cavb_pkg::REG_ROOM_SCALE: r_room      <= i_cfg_data;
                    cavb_pkg::REG_PRE_DELAY:  r_pre_delay <= i_cfg_data[cavb_pkg::PDLY_W-1:0];
                    default: r_room <= r_room;
                endcase
            end
            if (r_ovalid && !i_stall && r_state != S_O_SUM) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_clr == CLW'(CLR_N - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + CLW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_x     <= i_sample;
                        r_state <= S_PD_RD;
                    end
                end
                S_PD_RD: begin
                    r_d0    <= (pd_d == '0);
                    r_pidx  <= (r_pidx == PAW'(PREDELAY_DEPTH - 1)) ? '0 : (r_pidx + PAW'(1));
                    r_state <= S_PD_GET;
                end
                S_PD_GET: begin
                    r_wx    <= wx_c;
                    r_sum   <= '0;
                    r_k     <= '0;
                    r_state <= S_C_LEN;
                end
                S_C_LEN: r_state <= S_C_IDX;
                S_C_IDX: begin
                    r_len   <= len_c;
                    r_state <= S_C_RD;
                end
                S_C_RD: begin
                    r_ci    <= c_idx;
                    r_caddr <= cm_raddr;
                    r_state <= S_C_MUL1;
                end
                S_C_MUL1: r_state <= S_C_ST;
                S_C_ST: begin
                    r_store[r_k] <= st_new;
                    r_sum        <= sum_n;
                    r_state      <= S_C_MUL2;
                end
                S_C_MUL2: r_state <= S_C_WR;
                S_C_WR: begin
                    r_cidx[r_k] <= c_nxt;
                    if (r_k == KW'(cavb_pkg::NUM_COMBS - 1)) begin
                        r_k     <= '0;
                        r_a     <= a_sum;
                        r_state <= S_A_RD;
                    end else begin
                        r_k     <= r_k + KW'(1);
                        r_state <= S_C_LEN;
                    end
                end
                S_A_RD: begin
                    r_ai    <= a_idx;
                    r_state <= S_A_WR;
                end
                S_A_WR: begin
                    r_aidx[r_k[1:0]] <= a_nxt;
                    r_a              <= ap_a;
                    if (r_k[1:0] == 2'(cavb_pkg::NUM_AP - 1)) begin
                        r_k     <= '0;
                        r_state <= S_H_M1;
                    end else begin
                        r_k     <= r_k + KW'(1);
                        r_state <= S_A_RD;
                    end
                end
                S_H_M1: r_state <= S_H_M2;
                S_H_M2: begin
                    r_acc   <= r_prod;
                    r_state <= S_H_SUM;
                end
                S_H_SUM: begin
                    r_x1    <= r_a;
                    r_y1    <= hp_y;
                    r_a     <= hp_y;
                    r_state <= S_L_M1;
                end
                S_L_M1: r_state <= S_L_M2;
                S_L_M2: begin
                    r_acc   <= r_prod;
                    r_state <= S_L_SUM;
                end
                S_L_SUM: begin
                    r_lp    <= lp_y;
                    r_state <= S_O_M1;
                end
                S_O_M1: r_state <= S_O_M2;
                S_O_M2: begin
                    r_acc   <= r_prod;
                    r_state <= S_O_SUM;
                end
                S_O_SUM: begin
                    // hold until the output register is free
                    if (!r_ovalid || !i_stall) begin
                        r_out    <= out_s;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
